FILE: sv/bspline_de_boor_sampler_top_defines.svh
// Assertion macros shared by the sampler RTL.
`ifndef BSPLINE_DE_BOOR_SAMPLER_TOP_DEFINES_SVH
`define BSPLINE_DE_BOOR_SAMPLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define BDB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define BDB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BDB_ASSERT(label, prop, msg)
`define BDB_NEVER(label, cond, msg)
`endif
`endif

FILE: sv/bdb_pkg.sv
package bdb_pkg;

  localparam int MAX_CONTROLS = 256;
  localparam int MAX_DEGREE   = 8;
  localparam int KNOT_CAP     = MAX_CONTROLS + MAX_DEGREE + 1;

  localparam int CA_W  = $clog2(MAX_CONTROLS);   // control store address
  localparam int KA_W  = $clog2(KNOT_CAP);       // knot store address
  localparam int CNT_W = $clog2(KNOT_CAP + 1);   // fill counts
  localparam int TA_W  = $clog2(MAX_DEGREE + 1); // triangle address
  localparam int DEG_W = 6;
  localparam int IDX_W = 10;

  localparam int DVD_W = 64;  // divider dividend
  localparam int DVS_W = 33;  // divider divisor

  // input operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LD_CTRL = 2'd1;
  localparam logic [1:0] OP_LD_KNOT = 2'd2;
  localparam logic [1:0] OP_SAMPLE  = 2'd3;

  // output source select
  localparam logic [1:0] SEL_CTRL = 2'd0;
  localparam logic [1:0] SEL_RES  = 2'd1;
  localparam logic [1:0] SEL_KEEP = 2'd2;

  // register indexes
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_CLOSED = 1'b1;

  typedef struct packed {
    logic              capture;
    logic              clear;
    logic              ld_ctrl;
    logic              ld_knot;
    logic              ctrl_rd;
    logic [CA_W-1:0]   ctrl_addr;
    logic              knot_rd;
    logic [KA_W-1:0]   knot_addr;
    logic              lat_t0;
    logic              lat_t1;
    logic              mul_t;
    logic              div_start;
    logic              div_alpha;
    logic              lat_t;
    logic              set_t_t0;
    logic              lat_prev;
    logic              alpha_zero;
    logic              lat_alpha;
    logic              tri_wr_ld;
    logic              tri_rd;
    logic              tri_wr_blend;
    logic [TA_W-1:0]   tri_addr_a;
    logic [TA_W-1:0]   tri_addr_b;
    logic              mul_blend;
    logic              keep_res;
    logic              out_push;
    logic [1:0]        out_sel;
    logic              out_last;
    logic              out_fb;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CNT_W-1:0]  n;
    logic [CA_W-1:0]   idx8;
    logic              fallback;
    logic              idx_ge_n;
    logic              idx_last;
    logic              idx_gt_steps;
    logic              idx_is_steps;
    logic              sp_hit;
    logic              den_pos;
    logic              div_done;
    logic              div_busy;
    logic              differ;
    logic              out_free;
  } sts_t;

endpackage

FILE: sv/bdb_div.sv
module bdb_div import bdb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [DVD_W-1:0]        q_mag_o,
  output logic                    q_neg_o
);

  localparam int CW = $clog2(DVD_W);

  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   shift_rem, trial;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    shift_rem = {rem_q, quo_q[DVD_W-1]};
    ge        = shift_rem >= {1'b0, dvs_q};
    trial     = shift_rem - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    end else if (busy_q) begin
      rem_q <= ge ? trial[DVS_W-1:0] : shift_rem[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign q_mag_o = quo_q;
  assign q_neg_o = neg_q;

endmodule

FILE: sv/bdb_datapath.sv
`include "bspline_de_boor_sampler_top_defines.svh"
module bdb_datapath import bdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          in_op_i,
  input  logic signed [31:0]  in_px_i,
  input  logic signed [31:0]  in_py_i,
  input  logic signed [31:0]  in_knot_i,
  input  logic [IDX_W-1:0]    in_idx_i,
  input  logic [DEG_W-1:0]    deg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_x_o,
  output logic [31:0]         out_y_o,
  output logic                out_last_o,
  output logic                out_fb_o,
  output logic                out_ovf_o
);

  // captured transaction
  logic [1:0]         op_q;
  logic signed [31:0] px_q, py_q, kv_q;
  logic [IDX_W-1:0]   idx_q;

  logic [CNT_W-1:0]   cnt_ctrl_q, cnt_knot_q;
  logic               ovf_q;

  logic [63:0]        ctrl_mem [MAX_CONTROLS];
  logic signed [31:0] knot_mem [KNOT_CAP];
  logic [63:0]        tri_mem  [MAX_DEGREE+1];
  logic [63:0]        ctrl_rd_q;
  logic signed [31:0] knot_rd_q;
  logic [63:0]        tri_a_q, tri_b_q;

  logic signed [31:0] t0_q, t1_q, prev_q;
  logic signed [32:0] t_q, alpha_q;
  logic signed [43:0] prod_q;
  logic signed [65:0] mx_q, my_q;
  logic [63:0]        res_q, keep_q;

  logic               out_vld_q, out_last_q, out_fb_q, out_ovf_q;
  logic [31:0]        out_x_q, out_y_q;

  logic                    div_busy, div_done, div_neg;
  logic [DVD_W-1:0]        div_mag;
  logic signed [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0]        div_dvs;

  logic               ctrl_room, knot_room;
  logic [IDX_W-1:0]   steps;
  logic signed [32:0] diff_t, den, dx, dy;
  logic signed [33:0] tl, qs;
  logic signed [34:0] t_sum;
  logic [32:0]        amag;
  logic [63:0]        blend_res;
  logic [63:0]        out_src;

  function automatic logic [31:0] blend_round(logic signed [31:0] a, logic signed [65:0] m);
    logic signed [65:0] rnd;
    logic signed [35:0] sh;
    logic signed [36:0] s;
    rnd = m + 66'sd536870912;
    sh  = 36'(rnd >>> 30);
    s   = 37'(a) + 37'(sh);
    if (s > 37'sd2147483647)       blend_round = 32'h7fff_ffff;
    else if (s < -37'sd2147483648) blend_round = 32'h8000_0000;
    else                           blend_round = s[31:0];
  endfunction

  assign ctrl_room = cnt_ctrl_q < CNT_W'(MAX_CONTROLS);
  assign knot_room = cnt_knot_q < CNT_W'(KNOT_CAP);

  // capture input fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_op_i;
      px_q  <= in_px_i;
      py_q  <= in_py_i;
      kv_q  <= in_knot_i;
      idx_q <= in_idx_i;
    end
  end

  // fill counts and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_ctrl_q <= '0;
      cnt_knot_q <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_ctrl_q <= '0;
      cnt_knot_q <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.ld_ctrl) begin
      if (ctrl_room) cnt_ctrl_q <= cnt_ctrl_q + 1'b1;
      else           ovf_q      <= 1'b1;
    end else if (cmd_i.ld_knot) begin
      if (knot_room) cnt_knot_q <= cnt_knot_q + 1'b1;
      else           ovf_q      <= 1'b1;
    end
  end

  // control point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ctrl && ctrl_room) ctrl_mem[cnt_ctrl_q[CA_W-1:0]] <= {py_q, px_q};
    if (cmd_i.ctrl_rd) ctrl_rd_q <= ctrl_mem[cmd_i.ctrl_addr];
  end

  // knot store
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_knot && knot_room) knot_mem[cnt_knot_q[KA_W-1:0]] <= kv_q;
    if (cmd_i.knot_rd) knot_rd_q <= knot_mem[cmd_i.knot_addr];
  end

  // triangle scratch, two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.tri_wr_ld)         tri_mem[cmd_i.tri_addr_b] <= ctrl_rd_q;
    else if (cmd_i.tri_wr_blend) tri_mem[cmd_i.tri_addr_b] <= blend_res;
    if (cmd_i.tri_rd) begin
      tri_a_q <= tri_mem[cmd_i.tri_addr_a];
      tri_b_q <= tri_mem[cmd_i.tri_addr_b];
    end
  end

  // sample count: 8n clamped to 16..512
  always_comb begin
    if (cnt_ctrl_q >= CNT_W'(64))    steps = IDX_W'(512);
    else if (cnt_ctrl_q < CNT_W'(2)) steps = IDX_W'(16);
    else                             steps = IDX_W'({cnt_ctrl_q, 3'b000});
  end

  // arithmetic operands
  always_comb begin
    diff_t = 33'(t1_q) - 33'(t0_q);
    den    = 33'(knot_rd_q) - 33'(prev_q);
    tl     = 34'(t_q) - 34'(prev_q);
    qs     = div_neg ? -34'(div_mag[33:0]) : 34'(div_mag[33:0]);
    t_sum  = 35'(t0_q) + 35'(qs);
    amag   = (div_mag > 64'h8000_0000) ? 33'h0_8000_0000 : div_mag[32:0];
    dx     = 33'($signed(tri_b_q[31:0])) - 33'($signed(tri_a_q[31:0]));
    dy     = 33'($signed(tri_b_q[63:32])) - 33'($signed(tri_a_q[63:32]));
    blend_res = {blend_round($signed(tri_a_q[63:32]), my_q),
                 blend_round($signed(tri_a_q[31:0]), mx_q)};
    if (cmd_i.div_alpha) begin
      div_dvd = {tl, 30'b0};
      div_dvs = den[DVS_W-1:0];
    end else begin
      div_dvd = DVD_W'(prod_q);
      div_dvs = DVS_W'(steps);
    end
  end

  // parameter and blend registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_t0)   t0_q   <= knot_rd_q;
    if (cmd_i.lat_t1)   t1_q   <= knot_rd_q;
    if (cmd_i.mul_t)    prod_q <= diff_t * $signed({1'b0, idx_q});
    if (cmd_i.lat_t)    t_q    <= t_sum[32:0];
    else if (cmd_i.set_t_t0) t_q <= 33'(t0_q);
    if (cmd_i.lat_prev) prev_q <= knot_rd_q;
    if (cmd_i.alpha_zero)     alpha_q <= '0;
    else if (cmd_i.lat_alpha) alpha_q <= div_neg ? -$signed(amag) : $signed(amag);
    if (cmd_i.mul_blend) begin
      mx_q <= dx * alpha_q;
      my_q <= dy * alpha_q;
    end
    if (cmd_i.tri_wr_blend) res_q  <= blend_res;
    if (cmd_i.keep_res)     keep_q <= res_q;
  end

  bdb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .q_mag_o    (div_mag),
    .q_neg_o    (div_neg)
  );

  // output register
  always_comb begin
    case (cmd_i.out_sel)
      SEL_CTRL: out_src = ctrl_rd_q;
      SEL_RES:  out_src = res_q;
      SEL_KEEP: out_src = keep_q;
      default:  out_src = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      out_x_q    <= out_src[31:0];
      out_y_q    <= out_src[63:32];
      out_last_q <= cmd_i.out_last;
      out_fb_q   <= cmd_i.out_fb;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;
  assign out_fb_o    = out_fb_q;
  assign out_ovf_o   = out_ovf_q;

  // status
  always_comb begin
    sts_o.op           = op_q;
    sts_o.n            = cnt_ctrl_q;
    sts_o.idx8         = idx_q[CA_W-1:0];
    sts_o.fallback     = (deg_i == '0) || (deg_i > DEG_W'(MAX_DEGREE)) ||
                         (cnt_ctrl_q <= CNT_W'(deg_i)) ||
                         ({1'b0, cnt_knot_q} != ({1'b0, cnt_ctrl_q} + (CNT_W+1)'(deg_i) + 1'b1));
    sts_o.idx_ge_n     = {1'b0, idx_q} >= (IDX_W+1)'(cnt_ctrl_q);
    sts_o.idx_last     = ({1'b0, idx_q} + 1'b1) == (IDX_W+1)'(cnt_ctrl_q);
    sts_o.idx_gt_steps = idx_q > steps;
    sts_o.idx_is_steps = idx_q == steps;
    sts_o.sp_hit       = (t_q >= 33'(prev_q)) && (t_q <= 33'(knot_rd_q));
    sts_o.den_pos      = den > 33'sd0;
    sts_o.div_done     = div_done;
    sts_o.div_busy     = div_busy;
    sts_o.differ       = keep_q != res_q;
    sts_o.out_free     = !out_vld_q || out_ready_i;
  end

  `BDB_NEVER(a_ctrl_cnt_cap, cnt_ctrl_q > CNT_W'(MAX_CONTROLS), "control count above capacity")
  `BDB_NEVER(a_knot_cnt_cap, cnt_knot_q > CNT_W'(KNOT_CAP), "knot count above capacity")
  `BDB_ASSERT(a_ovf_cause, $rose(ovf_q) |-> $past(cmd_i.ld_ctrl || cmd_i.ld_knot), "overflow set without a load")

endmodule

FILE: sv/bdb_ctrl.sv
`include "bspline_de_boor_sampler_top_defines.svh"
module bdb_ctrl import bdb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DEG_W-1:0] deg_i,
  input  logic             closed_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_FB_OUT, S_T1_RD, S_T1_LAT, S_T_MUL, S_T_DIV, S_T_DIVW,
    S_SP_INIT, S_SP_PREV, S_SP_CMP, S_LD_RD, S_LD_WR, S_TR_LO, S_TR_HI,
    S_TR_DEN, S_TR_DIVW, S_TR_MUL, S_TR_WB, S_EVAL_DONE, S_OUT_A, S_OUT_B
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CA_W-1:0]   k_q, k_d;
  logic [TA_W-1:0]   j_q, j_d, r_q, r_d;
  logic              second_q, second_d;
  logic [TA_W-1:0]   d4;
  cmd_t              cmd;

  assign d4 = deg_i[TA_W-1:0];

  // sequencing and commands
  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    i_d      = i_q;
    k_d      = k_q;
    j_d      = j_q;
    r_d      = r_q;
    second_d = second_q;
    cmd.tri_addr_a = j_q - 1'b1;
    cmd.tri_addr_b = j_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_CLEAR:   cmd.clear   = 1'b1;
          OP_LD_CTRL: cmd.ld_ctrl = 1'b1;
          OP_LD_KNOT: cmd.ld_knot = 1'b1;
          OP_SAMPLE: begin
            if (sts_i.fallback) begin
              if (!sts_i.idx_ge_n) begin
                cmd.ctrl_rd   = 1'b1;
                cmd.ctrl_addr = sts_i.idx8;
                state_d       = S_FB_OUT;
              end
            end else if (!sts_i.idx_gt_steps) begin
              cmd.knot_rd   = 1'b1;
              cmd.knot_addr = KA_W'(d4);
              second_d      = 1'b0;
              state_d       = S_T1_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FB_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_sel  = SEL_CTRL;
          cmd.out_last = sts_i.idx_last;
          cmd.out_fb   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_T1_RD: begin
        cmd.lat_t0    = 1'b1;
        cmd.knot_rd   = 1'b1;
        cmd.knot_addr = KA_W'(sts_i.n);
        state_d       = S_T1_LAT;
      end
      S_T1_LAT: begin
        cmd.lat_t1 = 1'b1;
        state_d    = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.mul_t = 1'b1;
        state_d   = S_T_DIV;
      end
      S_T_DIV: begin
        cmd.div_start = 1'b1;
        state_d       = S_T_DIVW;
      end
      S_T_DIVW: begin
        if (sts_i.div_done) begin
          cmd.lat_t = 1'b1;
          state_d   = S_SP_INIT;
        end
      end
      // span search over the knots
      S_SP_INIT: begin
        cmd.knot_rd   = 1'b1;
        cmd.knot_addr = KA_W'(d4);
        i_d           = CNT_W'(d4);
        state_d       = S_SP_PREV;
      end
      S_SP_PREV: begin
        cmd.lat_prev  = 1'b1;
        cmd.knot_rd   = 1'b1;
        cmd.knot_addr = KA_W'(i_q + 1'b1);
        state_d       = S_SP_CMP;
      end
      S_SP_CMP: begin
        if (sts_i.sp_hit) begin
          k_d     = i_q[CA_W-1:0];
          j_d     = '0;
          state_d = S_LD_RD;
        end else if ((i_q + 1'b1) < sts_i.n) begin
          i_d           = i_q + 1'b1;
          cmd.lat_prev  = 1'b1;
          cmd.knot_rd   = 1'b1;
          cmd.knot_addr = KA_W'(i_q + CNT_W'(2));
        end else begin
          k_d     = CA_W'(d4);
          j_d     = '0;
          state_d = S_LD_RD;
        end
      end
      // seed the triangle with the local control points
      S_LD_RD: begin
        cmd.ctrl_rd   = 1'b1;
        cmd.ctrl_addr = k_q + CA_W'(j_q) - CA_W'(d4);
        state_d       = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.tri_wr_ld = 1'b1;
        if (j_q == d4) begin
          r_d     = TA_W'(1);
          state_d = S_TR_LO;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_LD_RD;
        end
      end
      // one blend step of the triangle
      S_TR_LO: begin
        cmd.knot_rd   = 1'b1;
        cmd.knot_addr = KA_W'(k_q) + KA_W'(j_q) - KA_W'(d4);
        state_d       = S_TR_HI;
      end
      S_TR_HI: begin
        cmd.lat_prev  = 1'b1;
        cmd.knot_rd   = 1'b1;
        cmd.knot_addr = KA_W'(k_q) + KA_W'(j_q) + 1'b1 - KA_W'(r_q);
        cmd.tri_rd    = 1'b1;
        state_d       = S_TR_DEN;
      end
      S_TR_DEN: begin
        if (sts_i.den_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_alpha = 1'b1;
          state_d       = S_TR_DIVW;
        end else begin
          cmd.alpha_zero = 1'b1;
          state_d        = S_TR_MUL;
        end
      end
      S_TR_DIVW: begin
        if (sts_i.div_done) begin
          cmd.lat_alpha = 1'b1;
          state_d       = S_TR_MUL;
        end
      end
      S_TR_MUL: begin
        cmd.mul_blend = 1'b1;
        state_d       = S_TR_WB;
      end
      S_TR_WB: begin
        cmd.tri_wr_blend = 1'b1;
        if (j_q > r_q) begin
          j_d     = j_q - 1'b1;
          state_d = S_TR_LO;
        end else if (r_q < d4) begin
          r_d     = r_q + 1'b1;
          j_d     = d4;
          state_d = S_TR_LO;
        end else begin
          state_d = S_EVAL_DONE;
        end
      end
      S_EVAL_DONE: begin
        if (second_q) begin
          state_d = S_OUT_A;
        end else if (sts_i.idx_is_steps && closed_i) begin
          // closing point: evaluate again at the start parameter
          cmd.keep_res = 1'b1;
          cmd.set_t_t0 = 1'b1;
          second_d     = 1'b1;
          state_d      = S_SP_INIT;
        end else if (sts_i.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_sel  = SEL_RES;
          cmd.out_last = sts_i.idx_is_steps;
          state_d      = S_IDLE;
        end
      end
      S_OUT_A: begin
        if (sts_i.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_sel  = SEL_KEEP;
          cmd.out_last = !sts_i.differ;
          state_d      = sts_i.differ ? S_OUT_B : S_IDLE;
        end
      end
      S_OUT_B: begin
        if (sts_i.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_sel  = SEL_RES;
          cmd.out_last = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      j_q      <= '0;
      r_q      <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      k_q      <= k_d;
      j_q      <= j_d;
      r_q      <= r_d;
      second_q <= second_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;
  assign cmd_o      = cmd;

  `BDB_NEVER(a_div_overlap, cmd.div_start && sts_i.div_busy, "divider restarted while busy")
  `BDB_NEVER(a_push_full, cmd.out_push && !sts_i.out_free, "result pushed into a full output stage")
  `BDB_ASSERT(a_tri_bounds, (state_q == S_TR_WB) |-> ((j_q >= r_q) && (r_q >= TA_W'(1)) && (j_q <= d4)), "triangle index out of range")

endmodule

FILE: sv/bspline_de_boor_sampler_top.sv
// B-spline sampler: load control points (op 1) and knots (op 2), then each sample
// request (op 3) returns at most one point, or two when a closed curve needs its start
// point appended. A curve sample divides for the parameter t, walks the knot span,
// seeds the triangle with d+1 control points, and runs d(d+1)/2 blend steps, each with
// a division for alpha unless the knot gap is not positive; one restoring divider is
// shared by t and the blend steps. A closing sample repeats the span walk, the seed
// and the triangle at the start parameter. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken in.
module bspline_de_boor_sampler_top import bdb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // point_x [31:0], point_y [63:32], knot_value [95:64], sample_index [105:96]
  input  logic [111:0]  s_axis_tdata,
  // op [1:0]
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_x [31:0], out_y [63:32]
  output logic [63:0]   m_axis_tdata,
  // used_fallback [0], store_overflow [1]
  output logic [1:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [DEG_W-1:0] deg_q;
  logic             closed_q;
  cmd_t             cmd;
  sts_t             sts;
  logic             wr_en;
  logic             fb, ovf;

  // configuration registers
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q    <= DEG_W'(3);
      closed_q <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == REG_DEGREE) deg_q    <= pwdata[DEG_W-1:0];
      else                        closed_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_CLOSED) ? {31'b0, closed_q} : {26'b0, deg_q};

  bdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .deg_i      (deg_q),
    .closed_i   (closed_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (s_axis_tuser),
    .in_px_i     (s_axis_tdata[31:0]),
    .in_py_i     (s_axis_tdata[63:32]),
    .in_knot_i   (s_axis_tdata[95:64]),
    .in_idx_i    (s_axis_tdata[105:96]),
    .deg_i       (deg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (m_axis_tdata[31:0]),
    .out_y_o     (m_axis_tdata[63:32]),
    .out_last_o  (m_axis_tlast),
    .out_fb_o    (fb),
    .out_ovf_o   (ovf)
  );

  assign m_axis_tuser = {ovf, fb};

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import bdb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 700;
  localparam int STALL_LEN   = 4000;

  // one output transaction
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        fb;
    logic        ovf;
  } sample_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = OP_CLEAR;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  bspline_de_boor_sampler_top dut (.*);

  // shadow of the curve state
  longint  ctrl_x [MAX_CONTROLS];
  longint  ctrl_y [MAX_CONTROLS];
  longint  knots [KNOT_CAP];
  int      n_ctrl, n_knot;
  longint  start_x, start_y;
  bit      ovf_flag;
  int      degree = 3;
  int      closed = 0;

  sample_t pending_q[$];
  int      fail_cnt, items_sent, curve_cnt, fb_cnt, closing_cnt, hits;
  int      cycles;
  logic    no_idle = 1'b0;
  logic    stall_tog = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // a + (b - a) * alpha, alpha in Q2.30, rounded half up
  function automatic longint mix_q30(longint a, longint b, longint alpha);
    longint p;
    p = (b - a) * alpha + (64'sd1 <<< 29);
    return clamp_s32(a + (p >>> 30));
  endfunction

  // de Boor evaluation at parameter t
  function automatic void curve_point(longint t, int n, int d, output longint px,
                                      output longint py);
    int     k, i, r, j;
    longint tx [MAX_DEGREE+1];
    longint ty [MAX_DEGREE+1];
    longint lo, den, al;
    k = d;
    for (i = d; i < n && i + 1 < KNOT_CAP; i++) begin
      if (t >= knots[i] && t <= knots[i+1]) begin
        k = i;
        break;
      end
    end
    for (j = 0; j <= d; j++) begin
      tx[j] = ctrl_x[(j + k - d) % MAX_CONTROLS];
      ty[j] = ctrl_y[(j + k - d) % MAX_CONTROLS];
    end
    for (r = 1; r <= d; r++) begin
      for (j = d; j >= r; j--) begin
        lo  = knots[(j + k - d) % KNOT_CAP];
        den = knots[(j + 1 + k - r) % KNOT_CAP] - lo;
        al  = 0;
        if (den > 0) begin
          al = ((t - lo) * (64'sd1 <<< 30)) / den;
          if (al > (64'sd2 <<< 30)) al = 64'sd2 <<< 30;
          if (al < -(64'sd2 <<< 30)) al = -(64'sd2 <<< 30);
        end
        tx[j] = mix_q30(tx[j-1], tx[j], al);
        ty[j] = mix_q30(ty[j-1], ty[j], al);
      end
    end
    px = tx[d];
    py = ty[d];
  endfunction

  function automatic void expect_point(longint px, longint py, bit last, bit fb);
    sample_t s;
    s.x = px[31:0];
    s.y = py[31:0];
    s.last = last;
    s.fb = fb;
    s.ovf = ovf_flag;
    pending_q.insert(pending_q.size(), s);
  endfunction

  function automatic int step_count(int n);
    int s;
    s = n * 8;
    if (s < 16) s = 16;
    if (s > 512) s = 512;
    return s;
  endfunction

  // update the shadow state for one accepted input transaction
  function automatic void predict_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] kn, logic [9:0] idx);
    int     st, i;
    longint t0, t1, t, qx, qy, fx, fy;
    i = int'(idx);
    case (op)
      OP_CLEAR: begin
        n_ctrl = 0;
        n_knot = 0;
        start_x = 0;
        start_y = 0;
        ovf_flag = 0;
      end
      OP_LD_CTRL: begin
        if (n_ctrl < MAX_CONTROLS) begin
          ctrl_x[n_ctrl] = longint'($signed(px));
          ctrl_y[n_ctrl] = longint'($signed(py));
          n_ctrl++;
        end else ovf_flag = 1;
      end
      OP_LD_KNOT: begin
        if (n_knot < KNOT_CAP) begin
          knots[n_knot] = longint'($signed(kn));
          n_knot++;
        end else ovf_flag = 1;
      end
      default: begin
        if (degree < 1 || degree > MAX_DEGREE || n_ctrl <= degree ||
            n_knot != n_ctrl + degree + 1) begin
          // control polygon fallback
          if (i < n_ctrl) begin
            expect_point(ctrl_x[i], ctrl_y[i], i + 1 == n_ctrl, 1);
            fb_cnt++;
          end
        end else begin
          st = step_count(n_ctrl);
          if (i <= st) begin
            t0 = knots[degree];
            t1 = knots[n_ctrl];
            t = t0 + ((t1 - t0) * longint'(i)) / longint'(st);
            curve_point(t, n_ctrl, degree, qx, qy);
            curve_cnt++;
            if (i == 0) begin
              start_x = qx;
              start_y = qy;
            end
            if (i != st) expect_point(qx, qy, 0, 0);
            else begin
              if (closed != 0) begin
                curve_point(t0, n_ctrl, degree, fx, fy);
                start_x = fx;
                start_y = fy;
              end
              if (closed != 0 && (fx[31:0] != qx[31:0] || fy[31:0] != qy[31:0])) begin
                expect_point(qx, qy, 0, 0);
                expect_point(fx, fy, 1, 0);
                closing_cnt++;
              end else expect_point(qx, qy, 1, 0);
            end
          end
        end
      end
    endcase
  endfunction

  // receiver: random backpressure, plus long holds on request
  always @(posedge clk_i) begin
    static int   hold_left = 0;
    static logic tog_seen = 1'b0;
    if (stall_tog != tog_seen) begin
      tog_seen = stall_tog;
      hold_left = STALL_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      hits++;
      if (pending_q.size() == 0) begin
        $error("unexpected result x=%h y=%h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== e.x) begin
          $error("out_x expected %h actual %h", e.x, m_axis_tdata[31:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $error("out_y expected %h actual %h", e.y, m_axis_tdata[63:32]);
          fail_cnt++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_point expected %b actual %b", e.last, m_axis_tlast);
          fail_cnt++;
        end
        if (m_axis_tuser[0] !== e.fb) begin
          $error("used_fallback expected %b actual %b", e.fb, m_axis_tuser[0]);
          fail_cnt++;
        end
        if (m_axis_tuser[1] !== e.ovf) begin
          $error("store_overflow expected %b actual %b", e.ovf, m_axis_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  // send one input transaction, with an optional idle gap first
  task automatic send_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                           logic [31:0] kn, logic [9:0] idx);
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, idx, kn, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(op, px, py, kn, idx);
    items_sent++;
  endtask

  // wait for every expected result, then out the worst-case evaluation time
  task automatic settle();
    int d;
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    d = (degree > MAX_DEGREE) ? MAX_DEGREE : degree;
    repeat (3 * (150 + 2 * n_ctrl + 2 * (d + 1) + 75 * d * (d + 1) / 2)) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_DEGREE) degree = val & 6'h3F;
    else closed = val & 1;
  endtask

  task automatic configure(int d, int c);
    settle();
    reg_write(REG_DEGREE, d);
    reg_write(REG_CLOSED, c);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
  endfunction

  // knot vector: mostly nondecreasing with repeats, sometimes scattered
  task automatic load_knots(int cnt);
    longint v;
    int     shape;
    shape = $urandom_range(0, 99);
    v = longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
    for (int i = 0; i < cnt; i++) begin
      if (shape < 15) v = longint'($signed($urandom()));
      else if ($urandom_range(0, 6) != 0) begin
        v = v + ((shape < 30) ? $urandom_range(0, 32'h0400_0000) :
                 $urandom_range(1, 32'h0004_0000));
        v = clamp_s32(v);
      end
      send_item(OP_LD_KNOT, $urandom(), $urandom(), v[31:0], 10'($urandom()));
    end
  endtask

  task automatic request_samples(int cnt);
    int st, r, idx;
    st = step_count(n_ctrl);
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) idx = st;
      else if (r < 22) idx = 0;
      else if (r < 26) idx = st + 1;
      else if (r < 30) idx = $urandom_range(0, 1023);
      else if (r < 45) idx = $urandom_range(0, n_ctrl + 1);
      else idx = $urandom_range(0, st);
      send_item(OP_SAMPLE, $urandom(), $urandom(), $urandom(), 10'(idx));
    end
  endtask

  // extremes of the fields, each operation, fallback, closing, degree limits
  task automatic test_directed();
    configure(1, 1);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    send_item(OP_LD_CTRL, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    send_item(OP_LD_CTRL, 32'h8000_0000, 32'h7FFF_FFFF, '0, 10'h3FF);
    send_item(OP_LD_KNOT, '0, '0, 32'h0000_0000, '0);
    send_item(OP_LD_KNOT, '0, '0, 32'h0000_0000, '0);
    send_item(OP_LD_KNOT, '0, '0, 32'h0001_0000, '0);
    send_item(OP_LD_KNOT, '0, '0, 32'h0001_0000, '0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd8);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd16);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd17);
    configure(0, 0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd1);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd2);
    configure(63, 1);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd1);
    configure(9, 0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd0);
    // knots going down: span search finds nothing
    configure(1, 1);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    send_item(OP_LD_CTRL, 32'h0003_0000, 32'hFFFF_0000, '0, '0);
    send_item(OP_LD_CTRL, 32'hFFFD_0000, 32'h0005_0000, '0, '0);
    for (int i = 0; i < 4; i++) send_item(OP_LD_KNOT, '0, '0, 32'h0004_0000 - i * 32'h1_0000, '0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd5);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd16);
  endtask

  // both stores overfilled; sticky flag rides on the results until clear
  task automatic test_store_overflow();
    configure(3, 0);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i <= MAX_CONTROLS; i++)
      send_item(OP_LD_CTRL, rand_coord(), rand_coord(), $urandom(), 10'($urandom()));
    for (int i = 0; i <= KNOT_CAP; i++)
      send_item(OP_LD_KNOT, $urandom(), $urandom(), $urandom(), 10'($urandom()));
    send_item(OP_SAMPLE, '0, '0, '0, 10'd0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd255);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd256);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    send_item(OP_LD_CTRL, $urandom(), $urandom(), '0, '0);
    send_item(OP_SAMPLE, '0, '0, '0, 10'd0);
  endtask

  // receiver holds off while samples keep coming
  task automatic test_backpressure();
    configure(2, 1);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < 4; i++) send_item(OP_LD_CTRL, rand_coord(), rand_coord(), '0, '0);
    load_knots(7);
    stall_tog <= ~stall_tog;
    request_samples(12);
  endtask

  // random curves: mostly well-formed setups with random content
  task automatic test_random_curves();
    int d, n, kc, phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      no_idle <= (phase >= 1 && phase < 4);
      d = $urandom_range(0, 99);
      if (d < 80) d = $urandom_range(1, 4);
      else if (d < 93) d = $urandom_range(5, MAX_DEGREE);
      else d = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_DEGREE + 1, 63);
      configure(d, $urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0) send_item(OP_CLEAR, $urandom(), $urandom(), $urandom(), '0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 10);
      if (d >= 1 && d <= MAX_DEGREE && n <= d) n = d + 1;
      for (int i = 0; i < n; i++) send_item(OP_LD_CTRL, rand_coord(), rand_coord(), $urandom(),
                                              10'($urandom()));
      kc = n + ((d <= MAX_DEGREE) ? d : 3) + 1;
      if ($urandom_range(0, 9) == 0) kc = kc + ($urandom_range(0, 1) ? 1 : -1);
      load_knots(kc);
      request_samples($urandom_range(4, 10));
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_overflow();
    test_backpressure();
    test_random_curves();
    settle();
    $display("%0d items sent: %0d curve samples, %0d fallback points, %0d closing pairs",
             items_sent, curve_cnt, fb_cnt, closing_cnt);
    $display("%0d results checked over degrees 0..63, open and closed curves", hits);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/bdb_pkg.sv
sv/bdb_div.sv
sv/bdb_datapath.sv
sv/bdb_ctrl.sv
sv/bspline_de_boor_sampler_top.sv
tb/sv/tb_top.sv
